// File: rtl/hotp_pkg.sv
`timescale 1ns / 1ps
package hotp_pkg;

  localparam int KEY_BYTES = 10;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [7:0] IPAD_BYTE = 8'h36;
  localparam logic [7:0] OPAD_BYTE = 8'h5c;

  // Reciprocal of 30 for a 21-bit dividend: (v * DIV30_RECIP) >> 26 == v / 30
  localparam logic [21:0] DIV30_RECIP = 22'd2236963;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  // Block selection for the compression unit
  typedef enum logic [1:0] {
    BLK_IPAD  = 2'd0,
    BLK_INNER = 2'd1,
    BLK_OPAD  = 2'd2,
    BLK_OUTER = 2'd3
  } blk_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     load;      // capture input word, start divide
    logic     div_step;  // one quotient digit
    logic     blk_init;  // load block into schedule, chain (IV for opad) into a..e
    logic     h_reset;   // chaining value back to IV
    logic     round;     // one SHA-1 round
    logic     fold;      // add a..e into chaining value
    logic     save_inner;// keep inner digest
    logic     trunc;     // dynamic truncation
    logic     mod_step;  // one reduction step
    logic     finish;    // drive result
    blk_sel_t blk;
  } hotp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic round_last;
    logic div_last;
    logic mod_last;
    logic time_mode;
  } hotp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  // Padded key byte i (0..63)
  function automatic logic [7:0] key_byte(input logic [79:0] key, input int i);
    key_byte = (i < KEY_BYTES && i < 10) ? key[79 - 8*i -: 8] : 8'h00;
  endfunction

endpackage

// File: rtl/hotp_ctrl.sv
`timescale 1ns / 1ps
module hotp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  hotp_pkg::hotp_sts_t sts,
  output hotp_pkg::hotp_cmd_t cmd
);
  import hotp_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_ROUND = 8'b0000_1000,
    S_FOLD  = 8'b0001_0000,
    S_TRUNC = 8'b0010_0000,
    S_MOD   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t   state, state_next;
  blk_sel_t blk, blk_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      blk   <= BLK_IPAD;
    end else begin
      state <= state_next;
      blk   <= blk_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequencing: divide (time mode only), four compressions, truncate, reduce
  always_comb begin
    state_next = state;
    blk_next   = blk;
    cmd        = '0;
    cmd.blk    = blk;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          blk_next  = BLK_IPAD;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.h_reset = 1'b1;
        if (!sts.time_mode || sts.div_last) state_next = S_INIT;
        else cmd.div_step = 1'b1;
        if (sts.time_mode) cmd.div_step = 1'b1;
      end
      S_INIT: begin
        cmd.blk_init = 1'b1;
        state_next   = S_ROUND;
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        if (sts.round_last) state_next = S_FOLD;
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        unique case (blk)
          BLK_IPAD:  begin blk_next = BLK_INNER; state_next = S_INIT; end
          BLK_INNER: begin
            cmd.save_inner = 1'b1;
            blk_next = BLK_OPAD; state_next = S_INIT;
          end
          BLK_OPAD:  begin blk_next = BLK_OUTER; state_next = S_INIT; end
          default:   state_next = S_TRUNC;
        endcase
      end
      S_TRUNC: begin
        cmd.trunc  = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_next = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // h_reset only at the step that leaves S_DIV and before first block
    if (state == S_DIV && !(!sts.time_mode || sts.div_last)) cmd.h_reset = 1'b0;
  end

  // Assertions
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_done_after_mod: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |-> $past(state) == S_MOD)
    else $error("result without reduction");
  a_start_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_DIV)
    else $error("start not taken");
endmodule

// File: rtl/hotp_dp.sv
`timescale 1ns / 1ps
module hotp_dp (
  input  logic                clk,
  input  logic                rst,
  input  hotp_pkg::hotp_cmd_t cmd,
  output hotp_pkg::hotp_sts_t sts,
  input  logic [15:0]         key_high,
  input  logic [63:0]         key_low,
  input  logic                action,
  input  logic [63:0]         moving_value,
  input  logic [19:0]         candidate_code,
  output logic                done,
  output logic                code_valid,
  output logic [19:0]         expected_code
);
  import hotp_pkg::*;

  logic [79:0]  key;
  logic         mode;
  logic [63:0]  ctr;      // dividend, then quotient
  logic [4:0]   rem;      // remainder < 30
  logic [1:0]   div_cnt;
  logic [19:0]  cand;
  logic [31:0]  w [16];
  logic [31:0]  a, b, c, d, e;
  logic [31:0]  h [5];
  logic [159:0] inner;
  logic [6:0]   rcnt;
  logic [31:0]  bin;      // reduced in place
  logic [4:0]   mcnt;

  assign key = {key_high, key_low};

  // Divide by 30, one 16-bit digit a cycle: reciprocal multiply, then remainder
  logic [20:0] dvd, drem, dq30;
  logic [42:0] dprod;
  logic [15:0] dq;
  assign dvd   = {rem, ctr[63:48]};
  assign dprod = {21'b0, dvd} * {21'b0, DIV30_RECIP};
  assign dq    = dprod[41:26];
  assign dq30  = {dq, 5'b0} - {4'b0, dq, 1'b0};
  assign drem  = dvd - dq30;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.load) begin
      ctr     <= moving_value;
      mode    <= action;
      cand    <= candidate_code;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 2'd1;
      rem     <= drem[4:0];
      ctr     <= {ctr[47:0], dq};
    end
  end

  // Message block for the current compression
  logic [511:0] blk_data;
  logic [159:0] hcat;
  assign hcat = {h[0], h[1], h[2], h[3], h[4]};

  always_comb begin
    blk_data = '0;
    unique case (cmd.blk)
      BLK_IPAD, BLK_OPAD: begin
        for (int i = 0; i < 64; i++)
          blk_data[511 - 8*i -: 8] = key_byte(key, i) ^
            ((cmd.blk == BLK_IPAD) ? IPAD_BYTE : OPAD_BYTE);
      end
      BLK_INNER: begin
        blk_data[511 -: 64] = ctr;
        blk_data[447 -: 8]  = 8'h80;
        blk_data[63:0]      = 64'd576;
      end
      default: begin
        blk_data[511 -: 160] = inner;
        blk_data[351 -: 8]   = 8'h80;
        blk_data[63:0]       = 64'd672;
      end
    endcase
  end

  // Round function
  logic [31:0] f, k, t, wnew;
  always_comb begin
    if (rcnt < 7'd20)      begin f = (b & c) | (~b & d);          k = 32'h5A827999; end
    else if (rcnt < 7'd40) begin f = b ^ c ^ d;                   k = 32'h6ED9EBA1; end
    else if (rcnt < 7'd60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
    else                   begin f = b ^ c ^ d;                   k = 32'hCA62C1D6; end
    t    = rotl(a, 5) + f + e + k + w[0];
    wnew = rotl(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
  end

  // Compression unit: schedule window, working vars, chaining value
  always_ff @(posedge clk) begin
    if (cmd.h_reset) begin
      h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
    end
    if (cmd.blk_init) begin
      for (int i = 0; i < 16; i++) w[i] <= blk_data[511 - 32*i -: 32];
      rcnt <= '0;
      if (cmd.blk == BLK_OPAD) begin
        a <= H0; b <= H1; c <= H2; d <= H3; e <= H4;
      end else begin
        a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
      end
      if (cmd.blk == BLK_OPAD) begin
        h[0] <= H0; h[1] <= H1; h[2] <= H2; h[3] <= H3; h[4] <= H4;
      end
    end else if (cmd.round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
      rcnt <= rcnt + 7'd1;
      e <= d; d <= c; c <= rotl(b, 30); b <= a; a <= t;
    end
    if (cmd.fold) begin
      h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
      h[3] <= h[3] + d; h[4] <= h[4] + e;
      if (cmd.save_inner)
        inner <= {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e};
    end
  end

  // Truncation and modulo by shift-subtract of 1000000 << j
  logic [3:0]  off;
  logic [31:0] sub;
  assign off = hcat[3:0];
  assign sub = 32'(64'd1000000 << (5'd11 - mcnt));

  always_ff @(posedge clk) begin
    if (cmd.trunc) begin
      bin  <= {1'b0, hcat[159 - 8*off - 1 -: 31]};
      mcnt <= '0;
    end else if (cmd.mod_step) begin
      mcnt <= mcnt + 5'd1;
      if (bin >= sub) bin <= bin - sub;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= cmd.finish;
    if (cmd.finish) begin
      expected_code <= bin[19:0];
      code_valid    <= (cand == bin[19:0]);
    end
  end

  assign sts.round_last = (rcnt == 7'd79);
  assign sts.div_last   = (div_cnt == 2'd3);
  assign sts.mod_last   = (mcnt == 5'd11);
  assign sts.time_mode  = mode;

  // Assertions
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> rem < 5'd30) else $error("remainder out of range");
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    done |-> expected_code < 20'd1000000) else $error("code out of range");
  a_valid_match: assert property (@(posedge clk) disable iff (rst)
    done && code_valid |-> expected_code == cand) else $error("bad match flag");
endmodule

// File: rtl/hmac_sha1_otp_validator.sv
`timescale 1ns / 1ps
// channel  | ports                                      | handshake
// config   | cfg_we, cfg_index, cfg_data[63:0]          | write when cfg_we high
// input    | action, moving_value, candidate_code       | start && !busy
// result   | code_valid, expected_code                  | done, one cycle
// Busy while it runs a setup step in counter mode, or in time mode a divide
// by 30 in 16-bit digits, then four SHA-1 compressions on one round unit, a
// truncation, modulo reduction and an output step; done follows in the next
// cycle, when a new word can be taken.
// Reset clears the key registers and the controller. No stall on results.
module hmac_sha1_otp_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        action,
  input  logic [63:0] moving_value,
  input  logic [19:0] candidate_code,
  output logic        done,
  output logic        code_valid,
  output logic [19:0] expected_code
);
  import hotp_pkg::*;

  logic [15:0] key_high;
  logic [63:0] key_low;
  hotp_cmd_t   cmd;
  hotp_sts_t   sts;

  // Key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_HIGH: key_high <= cfg_data[15:0];
        REG_KEY_LOW:  key_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  hotp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
  );

  hotp_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .key_high(key_high), .key_low(key_low),
    .action(action), .moving_value(moving_value), .candidate_code(candidate_code),
    .done(done), .code_valid(code_valid), .expected_code(expected_code)
  );
endmodule
